// ===== rtl/rprd_pkg.sv =====
// ----------------------------------------------------------------------------
// rprd_pkg
// Shared types and constants of the planar run-length row decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rprd_pkg;

	// Field widths.
	localparam int BYTE_W     = 8;
	localparam int COUNT_W    = 3;
	localparam int PLANE_W    = 3;
	localparam int ROW_W      = 10;
	localparam int COL_W      = 8;
	localparam int RUN_W      = 8;
	localparam int CFG_RB_W   = 8;
	localparam int CFG_PL_W   = 4;
	localparam int CFG_RC_W   = 11;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 2;

	// Bytes delivered per result.
	localparam int LANES = 4;

	// Register limits and reset values.
	localparam int MAX_PLANES      = 8;
	localparam int MAX_ROWS        = 1024;
	localparam int ROW_BYTES_RST   = 40;
	localparam int PLANE_COUNT_RST = 5;
	localparam int ROW_COUNT_RST   = 256;

	// Header byte codes.
	localparam int HDR_NOP  = 128;
	localparam int REP_BASE = 257;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd2;

	// Queue between decoder front and result back end.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LITERAL,
		PH_REPEAT,
		PH_SKIP
	} phase_t;

	// Clamped register values as the decoder uses them.
	typedef struct packed {
		logic [CFG_RB_W-1:0] row_bytes;
		logic [CFG_PL_W-1:0] planes;
		logic [CFG_RC_W-1:0] rows;
	} cfg_eff_t;

	// One placed run: n copies of value starting at col.
	typedef struct packed {
		logic [BYTE_W-1:0]  value;
		logic [RUN_W-1:0]   n;
		logic [COL_W-1:0]   col;
		logic [PLANE_W-1:0] plane;
		logic [ROW_W-1:0]   row;
		logic               row_end;
		logic               overrun;
		logic               done;
	} job_t;

	// Queue status seen by its two sides.
	typedef struct packed {
		logic full;
		logic valid;
	} q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/planar_runlength_row_decoder.sv =====
// ----------------------------------------------------------------------------
// planar_runlength_row_decoder
// Byte-run decoder for the body of a row-interleaved planar bitmap.
// ----------------------------------------------------------------------------
// Compressed body bytes enter one item at a time on the s_ side. A header
// below 128 starts a literal run, a header above 128 a repeat run, and a
// header of 128 is skipped. Decoded bytes leave on the m_ side, up to four
// per item, tagged with plane, row and column; m_tlast closes the results of
// one input byte and m_tuser carries the row end, overrun and image done
// flags. Bytes that would pass the end of a row are dropped and flagged.
// Header, skipped and post-image bytes give no result; a literal data byte
// gives one. A repeat run that places n bytes gives ceil(n/4) results, which
// the back end emits one per cycle while the receiver does not stall. A
// queue of four runs separates the decoder front from the back end, so the
// input stalls only once that queue fills. A result passes through the
// queue, the current-run register and the output register; when the
// receiver stalls, it holds in the output register and the queue backs up
// to the input. Reset restores the register defaults (40 bytes, 5 planes,
// 256 rows) and starts decoding at a header, as do defined register writes.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_runlength_row_decoder (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration write port.
	input  wire logic                              cfg_we,
	input  wire logic [rprd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [rprd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	// Compressed input.
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [7:0]                        s_tdata,  // stream_byte
	// Decoded output.
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// byte_zero, byte_one, byte_two, byte_three, byte_count, plane_index,
	// row_index, column_index
	output logic [55:0]                            m_tdata,
	output logic                                   m_tlast,  // run_end
	output logic [2:0]                             m_tuser   // row_end, overrun, image_done
);
	import rprd_pkg::*;

	logic [CFG_RB_W-1:0] row_bytes_q;
	logic [CFG_PL_W-1:0] plane_count_q;
	logic [CFG_RC_W-1:0] row_count_q;
	logic                clear;
	cfg_eff_t            cfg;
	q_stat_t             q_stat;
	logic                push;
	logic                pop;
	job_t                push_job;
	job_t                pop_job;

	// Only writes to a defined register restart the decoder.
	assign clear = cfg_we && ((cfg_index == REG_ROW_BYTES) ||
		(cfg_index == REG_PLANE_COUNT) || (cfg_index == REG_ROW_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q   <= CFG_RB_W'(ROW_BYTES_RST);
			plane_count_q <= CFG_PL_W'(PLANE_COUNT_RST);
			row_count_q   <= CFG_RC_W'(ROW_COUNT_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_BYTES:   row_bytes_q   <= cfg_wdata[CFG_RB_W-1:0];
				REG_PLANE_COUNT: plane_count_q <= cfg_wdata[CFG_PL_W-1:0];
				REG_ROW_COUNT:   row_count_q   <= cfg_wdata[CFG_RC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Out-of-range register values are clamped into the supported range.
	always_comb begin
		cfg.row_bytes = (row_bytes_q == '0) ? CFG_RB_W'(1) : row_bytes_q;
		if (plane_count_q == '0) begin
			cfg.planes = CFG_PL_W'(1);
		end else if (plane_count_q > CFG_PL_W'(MAX_PLANES)) begin
			cfg.planes = CFG_PL_W'(MAX_PLANES);
		end else begin
			cfg.planes = plane_count_q;
		end
		if (row_count_q == '0) begin
			cfg.rows = CFG_RC_W'(1);
		end else if (row_count_q > CFG_RC_W'(MAX_ROWS)) begin
			cfg.rows = CFG_RC_W'(MAX_ROWS);
		end else begin
			cfg.rows = row_count_q;
		end
	end

	rprd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (clear),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	rprd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.stat     (q_stat)
	);

	rprd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop_job  (pop_job),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// ===== rtl/rprd_queue.sv =====
// ----------------------------------------------------------------------------
// rprd_queue
// Small first-in first-out queue of decoded runs.
// ----------------------------------------------------------------------------
`default_nettype none

module rprd_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire rprd_pkg::job_t  push_job,
	input  wire logic            pop,
	output rprd_pkg::job_t       pop_job,
	output rprd_pkg::q_stat_t    stat
);
	import rprd_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign stat.valid = (count_q != '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && stat.valid;
	assign pop_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rprd_front.sv =====
// ----------------------------------------------------------------------------
// rprd_front
// Accepts compressed bytes, tracks header and run phases and places each
// data byte or repeat run into the row, plane and column grid.
// ----------------------------------------------------------------------------
`default_nettype none

module rprd_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          clear,
	input  wire rprd_pkg::cfg_eff_t            cfg,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [rprd_pkg::BYTE_W-1:0]   s_tdata,
	input  wire rprd_pkg::q_stat_t             q_stat,
	output logic                               push,
	output rprd_pkg::job_t                     push_job
);
	import rprd_pkg::*;

	phase_t             phase_q, phase_d;
	logic [RUN_W-1:0]   remaining_q, remaining_d;
	logic [COL_W-1:0]   column_q, column_d;
	logic [PLANE_W-1:0] plane_q, plane_d;
	logic [ROW_W-1:0]   row_q, row_d;
	logic               finished_q, finished_d;

	logic               step;
	logic [BYTE_W-1:0]  v;
	logic [RUN_W-1:0]   rem_dec;
	logic [COL_W:0]     col_next;
	logic               lit_end;
	logic [COL_W-1:0]   space;
	logic               rep_ovr;
	logic               rep_end;
	logic [RUN_W-1:0]   rep_n;
	logic [CFG_PL_W-1:0] plane_inc;
	logic [CFG_RC_W-1:0] row_inc;
	logic               wrap;
	logic               adv_done;

	assign v = s_tdata;

	// Data phases need a queue slot; header and skipped bytes do not.
	assign s_tready = finished_q || !q_stat.full ||
		(phase_q == PH_HEADER) || (phase_q == PH_SKIP);
	assign step = s_tvalid && s_tready && !finished_q;

	assign rem_dec  = remaining_q - 1'b1;
	assign col_next = {1'b0, column_q} + 1'b1;
	assign lit_end  = (col_next >= {1'b0, cfg.row_bytes});

	// The column always stays below the row length, so space is at least one.
	assign space   = cfg.row_bytes - column_q;
	assign rep_ovr = (remaining_q > space);
	assign rep_end = (remaining_q >= space);
	assign rep_n   = rep_ovr ? space : remaining_q;

	assign plane_inc = {1'b0, plane_q} + 1'b1;
	assign row_inc   = {1'b0, row_q} + 1'b1;
	assign wrap      = (plane_inc >= cfg.planes);
	assign adv_done  = wrap && (row_inc >= cfg.rows);

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_HEADER: begin
				if (v < BYTE_W'(HDR_NOP)) begin
					phase_d = PH_LITERAL;
				end else if (v > BYTE_W'(HDR_NOP)) begin
					phase_d = PH_REPEAT;
				end
			end
			PH_LITERAL: begin
				if (lit_end) begin
					phase_d = (rem_dec != '0) ? PH_SKIP : PH_HEADER;
				end else if (rem_dec == '0) begin
					phase_d = PH_HEADER;
				end
			end
			PH_REPEAT: begin
				phase_d = PH_HEADER;
			end
			PH_SKIP: begin
				if (remaining_q <= RUN_W'(1)) begin
					phase_d = PH_HEADER;
				end
			end
			default: phase_d = PH_HEADER;
		endcase
	end

	// Counters and the run handed to the back end.
	always_comb begin
		push           = 1'b0;
		push_job.value = v;
		push_job.n     = RUN_W'(1);
		push_job.col   = column_q;
		push_job.plane = plane_q;
		push_job.row   = row_q;
		push_job.row_end = 1'b0;
		push_job.overrun = 1'b0;
		push_job.done    = 1'b0;
		remaining_d = remaining_q;
		column_d    = column_q;
		plane_d     = plane_q;
		row_d       = row_q;
		finished_d  = finished_q;
		unique case (phase_q)
			PH_HEADER: begin
				if (v < BYTE_W'(HDR_NOP)) begin
					remaining_d = v + 1'b1;
				end else if (v > BYTE_W'(HDR_NOP)) begin
					remaining_d = RUN_W'(9'(REP_BASE) - {1'b0, v});
				end
			end
			PH_LITERAL: begin
				push             = step;
				push_job.row_end = lit_end;
				push_job.overrun = lit_end && (rem_dec != '0);
				push_job.done    = lit_end && adv_done;
				remaining_d      = rem_dec;
				column_d         = lit_end ? '0 : col_next[COL_W-1:0];
				if (lit_end) begin
					plane_d    = wrap ? '0 : plane_inc[PLANE_W-1:0];
					row_d      = wrap ? row_inc[ROW_W-1:0] : row_q;
					finished_d = adv_done;
				end
			end
			PH_REPEAT: begin
				push             = step;
				push_job.n       = rep_n;
				push_job.row_end = rep_end;
				push_job.overrun = rep_ovr;
				push_job.done    = rep_end && adv_done;
				remaining_d      = '0;
				column_d         = rep_end ? '0 : column_q + rep_n;
				if (rep_end) begin
					plane_d    = wrap ? '0 : plane_inc[PLANE_W-1:0];
					row_d      = wrap ? row_inc[ROW_W-1:0] : row_q;
					finished_d = adv_done;
				end
			end
			PH_SKIP: begin
				remaining_d = (remaining_q != '0) ? rem_dec : '0;
			end
			default: begin
				remaining_d = remaining_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			remaining_q <= '0;
			column_q    <= '0;
			plane_q     <= '0;
			row_q       <= '0;
			finished_q  <= 1'b0;
		end else if (clear) begin
			phase_q     <= PH_HEADER;
			remaining_q <= '0;
			column_q    <= '0;
			plane_q     <= '0;
			row_q       <= '0;
			finished_q  <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			column_q    <= column_d;
			plane_q     <= plane_d;
			row_q       <= row_d;
			finished_q  <= finished_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rprd_back.sv =====
// ----------------------------------------------------------------------------
// rprd_back
// Takes placed runs from the queue and emits them in groups of up to four
// bytes through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rprd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rprd_pkg::q_stat_t q_stat,
	input  wire rprd_pkg::job_t    pop_job,
	output logic                   pop,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [55:0]            m_tdata,
	output logic                   m_tlast,
	output logic [2:0]             m_tuser
);
	import rprd_pkg::*;

	job_t               cur_q;
	logic               busy_q;
	logic               out_valid_q;
	logic [55:0]        out_data_q;
	logic               out_last_q;
	logic [2:0]         out_user_q;

	logic               advance;
	logic               last;
	logic [COUNT_W-1:0] cnt;
	logic [BYTE_W-1:0]  lane_byte [LANES];

	assign last    = (cur_q.n <= RUN_W'(LANES));
	assign cnt     = last ? cur_q.n[COUNT_W-1:0] : COUNT_W'(LANES);
	assign advance = busy_q && (!out_valid_q || m_tready);
	assign pop     = q_stat.valid && (!busy_q || (advance && last));

	// Lanes past the count read as zero.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			lane_byte[i] = (cnt > COUNT_W'(i)) ? cur_q.value : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_job;
		end else if (advance) begin
			cur_q.n   <= cur_q.n - RUN_W'(cnt);
			cur_q.col <= cur_q.col + COL_W'(cnt);
		end
		if (advance) begin
			out_data_q <= {cur_q.col, cur_q.row, cur_q.plane, cnt,
				lane_byte[3], lane_byte[2], lane_byte[1], lane_byte[0]};
			out_last_q <= last;
			out_user_q <= {last && cur_q.done, last && cur_q.overrun,
				last && cur_q.row_end};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (advance && last) begin
				busy_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_user_q;

endmodule

`default_nettype wire
